// File: hdl/fit_policy_partition_allocator_core_macros.svh
// assertion macros shared by the allocator checker
`ifndef FIT_POLICY_PARTITION_ALLOCATOR_CORE_MACROS_SVH
`define FIT_POLICY_PARTITION_ALLOCATOR_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define FPA_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("fpa check failed");

// next-cycle implication, disabled while reset is held
`define FPA_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("fpa check failed");

`endif

// File: hdl/fpa_pkg.sv
// shared types and codes for the fit-policy partition allocator
package fpa_pkg;

    // input word kinds carried on s_tuser
    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    // configuration register indexes
    localparam int          CFG_ADDR_W    = 1;
    localparam int          CFG_DATA_W    = 4;
    localparam logic [0:0]  REG_FIT_MODE  = 1'b0;
    localparam logic [0:0]  REG_PART_CNT  = 1'b1;

    // stream field widths
    localparam int IDX_FIELD_W = 3;
    localparam int AMT_FIELD_W = 16;
    localparam int TDATA_W     = 24;

    // placement policies (code three falls back to first fit)
    typedef enum logic [1:0] {
        FIT_FIRST = 2'd0,
        FIT_BEST  = 2'd1,
        FIT_WORST = 2'd2
    } fit_mode_t;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_WRITE
    } fpa_state_t;

endpackage

// File: hdl/fit_policy_partition_allocator_core.sv
// fit-policy partition allocator: capacity memory, scan sequencer and result register
//
//  channel   direction  handshake            payload
//  s_        in         s_tvalid / s_tready  tuser op, tdata index + amount
//  m_        out        m_tvalid / m_tready  tuser granted, tdata partition + left over
//  cfg_      in         cfg_wr_en            cfg_addr register, cfg_wdata value
//
// a load word produces no result
// a request scans the active partitions, then drains the compare and writes its result:
// one partition per cycle is read from the capacity memory and fed through the shared
// compare unit; the result write waits while the previous result still waits on m_tready
// s_tready is low from a request's acceptance until its result enters the output register
// aresetn is synchronous, active low; valid bits make every partition read as zero capacity
module fit_policy_partition_allocator_core #(
    parameter int MAX_PARTITIONS = 8,
    parameter int SIZE_BITS      = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration write port
    input  logic                          cfg_wr_en,
    input  logic [fpa_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [fpa_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic                          s_tuser,   // operation
    input  logic [fpa_pkg::TDATA_W-1:0]   s_tdata,   // partition_index[2:0], amount[18:3]
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic                          m_tuser,   // granted
    output logic [fpa_pkg::TDATA_W-1:0]   m_tdata    // chosen_partition[2:0], left_over[18:3]
);
    import fpa_pkg::*;

    localparam int IDX_W = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
    localparam int CNT_W = $clog2(MAX_PARTITIONS + 1);
    localparam int AMT_W = (SIZE_BITS > AMT_FIELD_W) ? SIZE_BITS : AMT_FIELD_W;
    localparam int PIX_W = (IDX_W > IDX_FIELD_W) ? IDX_W : IDX_FIELD_W;
    localparam int PAD_W = TDATA_W - IDX_FIELD_W - AMT_FIELD_W;

    // configuration registers
    logic [1:0]           fit_mode_reg;
    logic [3:0]           part_cnt_reg;

    // capacity memory and per-entry valid bits
    logic [SIZE_BITS-1:0] cap_mem [MAX_PARTITIONS];
    logic [MAX_PARTITIONS-1:0] cap_vld_reg;
    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    logic [SIZE_BITS-1:0] mem_wdata;
    logic [IDX_W-1:0]     rd_addr;
    logic [SIZE_BITS-1:0] rd_data_reg;
    logic                 rd_vld_reg;

    // sequencer and scan state
    fpa_state_t           state_reg, state_next;
    logic [CNT_W-1:0]     issue_reg, issue_next;
    logic                 cmp_vld_reg;
    logic [IDX_W-1:0]     cmp_idx_reg;
    logic [SIZE_BITS-1:0] amt_reg, amt_next;
    logic                 found_reg, found_next;
    logic [IDX_W-1:0]     pick_reg, pick_next;
    logic [SIZE_BITS-1:0] best_reg, best_next;

    // output register
    logic                 m_tvalid_reg, m_tvalid_next;
    logic                 m_tuser_reg, m_tuser_next;
    logic [TDATA_W-1:0]   m_tdata_reg, m_tdata_next;

    // decoded input fields
    logic [IDX_FIELD_W-1:0] in_idx;
    logic [AMT_W-1:0]       in_amt_wide;
    logic [SIZE_BITS-1:0]   in_amt;
    logic [PIX_W-1:0]       in_idx_wide;
    logic                   load_ok;

    // shared compare unit and write-back arithmetic
    logic [SIZE_BITS-1:0] cap_val;
    logic                 qualifies;
    logic                 better;
    logic [SIZE_BITS-1:0] left_val;
    logic [AMT_W-1:0]     left_wide;
    logic [PIX_W-1:0]     pick_wide;

    // active partition count, saturated at the memory depth
    logic [7:0]           cnt8;
    logic [CNT_W-1:0]     active_cnt;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tdata  = m_tdata_reg;

    assign in_idx      = s_tdata[IDX_FIELD_W-1:0];
    assign in_amt_wide = AMT_W'(s_tdata[IDX_FIELD_W +: AMT_FIELD_W]);
    assign in_amt      = in_amt_wide[SIZE_BITS-1:0];
    assign in_idx_wide = PIX_W'(in_idx);
    assign load_ok     = (32'(in_idx) < MAX_PARTITIONS);

    assign cnt8       = (8'(part_cnt_reg) > 8'(MAX_PARTITIONS)) ? 8'(MAX_PARTITIONS)
                                                               : 8'(part_cnt_reg);
    assign active_cnt = CNT_W'(cnt8);

    assign rd_addr = issue_reg[IDX_W-1:0];

    // compare the partition read last cycle against the request and the current pick
    assign cap_val   = rd_vld_reg ? rd_data_reg : '0;
    assign qualifies = (cap_val >= amt_reg);
    always_comb begin
        case (fit_mode_reg)
            FIT_BEST:  better = (cap_val < best_reg);
            FIT_WORST: better = (cap_val > best_reg);
            default:   better = 1'b0;
        endcase
    end

    assign left_val  = best_reg - amt_reg;
    assign left_wide = AMT_W'(left_val);
    assign pick_wide = PIX_W'(pick_reg);

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fit_mode_reg <= FIT_FIRST;
            part_cnt_reg <= 4'd8;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_FIT_MODE: fit_mode_reg <= cfg_wdata[1:0];
                REG_PART_CNT: part_cnt_reg <= cfg_wdata[3:0];
                default:      ;
            endcase
        end
    end

    // capacity memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            cap_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= cap_mem[rd_addr];
    end

    // valid bits, cleared by reset so unwritten partitions hold no capacity
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_vld_reg <= '0;
            rd_vld_reg  <= 1'b0;
        end else begin
            if (mem_we) begin
                cap_vld_reg[mem_waddr] <= 1'b1;
            end
            rd_vld_reg <= cap_vld_reg[rd_addr];
        end
    end

    // state register and datapath registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cmp_vld_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
            found_reg    <= 1'b0;
            issue_reg    <= '0;
        end else begin
            state_reg    <= state_next;
            cmp_vld_reg  <= (state_reg == ST_SCAN);
            m_tvalid_reg <= m_tvalid_next;
            found_reg    <= found_next;
            issue_reg    <= issue_next;
        end
        cmp_idx_reg <= rd_addr;
        amt_reg     <= amt_next;
        pick_reg    <= pick_next;
        best_reg    <= best_next;
        m_tuser_reg <= m_tuser_next;
        m_tdata_reg <= m_tdata_next;
    end

    // sequencer: next state, scan bookkeeping, write-back and result
    always_comb begin
        state_next    = state_reg;
        issue_next    = issue_reg;
        amt_next      = amt_reg;
        found_next    = found_reg;
        pick_next     = pick_reg;
        best_next     = best_reg;
        mem_we        = 1'b0;
        mem_waddr     = in_idx_wide[IDX_W-1:0];
        mem_wdata     = in_amt;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tuser_next  = m_tuser_reg;
        m_tdata_next  = m_tdata_reg;

        // fold in the partition whose capacity arrived this cycle
        if (cmp_vld_reg && qualifies && (!found_reg || better)) begin
            found_next = 1'b1;
            pick_next  = cmp_idx_reg;
            best_next  = cap_val;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser == OP_LOAD) begin
                        mem_we = load_ok;
                    end else begin
                        amt_next   = in_amt;
                        found_next = 1'b0;
                        issue_next = '0;
                        state_next = (active_cnt == '0) ? ST_WRITE : ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                issue_next = issue_reg + CNT_W'(1);
                if (issue_reg == active_cnt - CNT_W'(1)) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_WRITE;
            end
            ST_WRITE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = found_reg;
                    if (found_reg) begin
                        mem_we       = 1'b1;
                        mem_waddr    = pick_reg;
                        mem_wdata    = left_val;
                        m_tdata_next = {PAD_W'(0), left_wide[AMT_FIELD_W-1:0],
                                        pick_wide[IDX_FIELD_W-1:0]};
                    end else begin
                        m_tdata_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: hdl/fpa_chk.sv
// port-level checks for the allocator core and their bind
`include "fit_policy_partition_allocator_core_macros.svh"

module fpa_chk #(
    parameter int MAX_PARTITIONS = 8
) (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic                        s_tuser,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic                        m_tuser,
    input logic [fpa_pkg::TDATA_W-1:0] m_tdata
);
    import fpa_pkg::*;

    logic req_acc;
    assign req_acc = s_tvalid && s_tready && (s_tuser == OP_REQUEST);

    // a refused request reports partition zero and nothing left over
    `FPA_ASSERT_NOW(a_refused_zero, aclk, aresetn, m_tvalid && !m_tuser, m_tdata == '0)

    // an accepted request takes s_tready low, holding off the input
    `FPA_ASSERT_NEXT(a_req_busy, aclk, aresetn, req_acc, !s_tready)

    // a granted partition lies inside the memory
    `FPA_ASSERT_NOW(a_pick_range, aclk, aresetn, m_tvalid && m_tuser,
                    (32'(m_tdata[2:0]) < MAX_PARTITIONS) || (MAX_PARTITIONS > 8))

    // a stalled result word keeps its payload
    `FPA_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready,
                     m_tvalid && $stable(m_tdata) && $stable(m_tuser))

endmodule

bind fit_policy_partition_allocator_core fpa_chk #(
    .MAX_PARTITIONS(MAX_PARTITIONS)
) u_fpa_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tuser  (m_tuser),
    .m_tdata  (m_tdata)
);

// File: sim/fit_policy_partition_allocator_core_tb.sv
// self-checking testbench for the fit-policy partition allocator core
`timescale 1ns / 1ps

module fit_policy_partition_allocator_core_tb;
    import fpa_pkg::*;

    localparam int          NUM_PARTS       = 8;
    localparam int          NUM_PHASES      = 8;
    localparam int          WORDS_PER_PHASE = 228;
    localparam int          SETTLE_CYCLES   = 16;
    localparam int          CYCLE_LIMIT     = 600000;
    localparam int          MAX_REPORTS     = 100;
    localparam logic [1:0]  FIT_FALLBACK    = 2'd3;   // undefined code, acts as first fit

    typedef struct packed {
        logic        ok;
        logic [2:0]  part;
        logic [15:0] left;
    } grant_t;

    typedef enum logic [1:0] {ROW_CFG, ROW_LOAD, ROW_REQ} row_kind_t;

    // for register rows, idx carries the register index and amt the value
    typedef struct packed {
        row_kind_t   kind;
        logic [2:0]  idx;
        logic [15:0] amt;
        logic        typed;
        grant_t      want;
    } dir_row_t;

    localparam grant_t NO_GRANT = '{1'b0, 3'd0, 16'd0};

    // directed table, starting from reset: first fit, eight partitions, all empty
    localparam int NUM_DIR_ROWS = 31;
    localparam dir_row_t DIR_ROWS [NUM_DIR_ROWS] = '{
        '{ROW_REQ,  3'd7, 16'd0,     1'b1, '{1'b1, 3'd0, 16'd0}},
        '{ROW_REQ,  3'd0, 16'd1,     1'b1, NO_GRANT},
        '{ROW_LOAD, 3'd0, 16'hFFFF,  1'b0, NO_GRANT},
        '{ROW_LOAD, 3'd7, 16'hFFFF,  1'b0, NO_GRANT},
        '{ROW_REQ,  3'd3, 16'hFFFF,  1'b1, '{1'b1, 3'd0, 16'd0}},
        '{ROW_REQ,  3'd4, 16'hFFFF,  1'b1, '{1'b1, 3'd7, 16'd0}},
        '{ROW_LOAD, 3'd1, 16'd100,   1'b0, NO_GRANT},
        '{ROW_LOAD, 3'd2, 16'd50,    1'b0, NO_GRANT},
        '{ROW_LOAD, 3'd3, 16'd200,   1'b0, NO_GRANT},
        '{ROW_REQ,  3'd0, 16'd0,     1'b1, '{1'b1, 3'd0, 16'd0}},
        '{ROW_CFG,  3'(REG_FIT_MODE), 16'(FIT_BEST),     1'b0, NO_GRANT},
        '{ROW_REQ,  3'd0, 16'd40,    1'b0, NO_GRANT},
        '{ROW_CFG,  3'(REG_FIT_MODE), 16'(FIT_WORST),    1'b0, NO_GRANT},
        '{ROW_REQ,  3'd0, 16'd40,    1'b0, NO_GRANT},
        '{ROW_CFG,  3'(REG_FIT_MODE), 16'(FIT_FALLBACK), 1'b0, NO_GRANT},
        '{ROW_REQ,  3'd0, 16'd40,    1'b0, NO_GRANT},
        '{ROW_CFG,  3'(REG_PART_CNT), 16'd2,  1'b0, NO_GRANT},
        '{ROW_LOAD, 3'd5, 16'd500,   1'b0, NO_GRANT},
        '{ROW_REQ,  3'd0, 16'd300,   1'b1, NO_GRANT},
        '{ROW_CFG,  3'(REG_PART_CNT), 16'd0,  1'b0, NO_GRANT},
        '{ROW_REQ,  3'd0, 16'd0,     1'b1, NO_GRANT},
        '{ROW_CFG,  3'(REG_PART_CNT), 16'd15, 1'b0, NO_GRANT},
        '{ROW_REQ,  3'd0, 16'd300,   1'b0, NO_GRANT},
        '{ROW_CFG,  3'(REG_FIT_MODE), 16'(FIT_WORST),    1'b0, NO_GRANT},
        '{ROW_LOAD, 3'd4, 16'd200,   1'b0, NO_GRANT},
        '{ROW_REQ,  3'd0, 16'd10,    1'b0, NO_GRANT},
        '{ROW_CFG,  3'(REG_FIT_MODE), 16'(FIT_BEST),     1'b0, NO_GRANT},
        '{ROW_REQ,  3'd0, 16'd60,    1'b0, NO_GRANT},
        '{ROW_REQ,  3'd0, 16'hFFFF,  1'b1, NO_GRANT},
        '{ROW_CFG,  3'(REG_PART_CNT), 16'd8,  1'b0, NO_GRANT},
        '{ROW_CFG,  3'(REG_FIT_MODE), 16'(FIT_FIRST),    1'b0, NO_GRANT}
    };

    // register settings for the random phases
    localparam logic [1:0] PHASE_FIT [NUM_PHASES] = '{
        FIT_FIRST, FIT_BEST, FIT_WORST, FIT_FALLBACK,
        FIT_BEST, FIT_WORST, FIT_FIRST, FIT_FALLBACK
    };
    localparam logic [3:0] PHASE_COUNT [NUM_PHASES] = '{
        4'd8, 4'd1, 4'd15, 4'd5, 4'd9, 4'd3, 4'd8, 4'd6
    };

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic                   s_tuser = 1'b0;
    logic [TDATA_W-1:0]     s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic                   m_tuser;
    logic [TDATA_W-1:0]     m_tdata;

    // predictor state
    logic [15:0]            part_cap [NUM_PARTS];
    logic [1:0]             cur_fit;
    logic [3:0]             cur_count;
    grant_t                 pending_grants [$];

    int                     sender_idle_pct = 0;
    int                     recv_stall_pct = 0;
    int                     mismatch_count = 0;
    int                     result_count = 0;
    int                     load_count = 0;
    int                     request_count = 0;
    int                     granted_count = 0;
    int                     reg_write_count = 0;
    int                     cycle_count = 0;

    fit_policy_partition_allocator_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tuser   (m_tuser),
        .m_tdata   (m_tdata)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // pick a partition for a request and take the amount out of it
    function automatic grant_t predict_grant(logic [15:0] amt);
        grant_t g;
        int     active;
        g = NO_GRANT;
        active = (cur_count > NUM_PARTS) ? NUM_PARTS : int'(cur_count);
        for (int j = 0; j < active; j++) begin
            if (part_cap[j] >= amt) begin
                if (!g.ok) begin
                    g.ok = 1'b1;
                    g.part = 3'(j);
                    if (cur_fit != FIT_BEST && cur_fit != FIT_WORST) break;
                end else if (cur_fit == FIT_BEST && part_cap[j] < part_cap[g.part]) begin
                    g.part = 3'(j);
                end else if (cur_fit == FIT_WORST && part_cap[j] > part_cap[g.part]) begin
                    g.part = 3'(j);
                end
            end
        end
        if (g.ok) begin
            part_cap[g.part] = part_cap[g.part] - amt;
            g.left = part_cap[g.part];
        end
        return g;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("mismatch: %s at result %0d, got %0h expected %0h",
                     what, result_count, got, want);
    endtask

    // present one word, wait for its handshake, then update the predictor
    task automatic issue_word(logic op, logic [2:0] idx, logic [15:0] amt,
                              logic typed, grant_t typed_want);
        grant_t want;
        if ($urandom_range(0, 99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < sender_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {5'd0, amt, idx};
        do @(posedge aclk); while (!s_tready);
        if (op == OP_LOAD) begin
            part_cap[idx] = amt;
            load_count++;
        end else begin
            want = predict_grant(amt);
            if (typed) want = typed_want;
            pending_grants.push_back(want);
            request_count++;
            if (want.ok) granted_count++;
        end
    endtask

    // let every pending result drain, then give a trailing load time to finish
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_grants.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (addr == REG_FIT_MODE) cur_fit = val[1:0];
        else cur_count = val[3:0];
        reg_write_count++;
    endtask

    // receiver backpressure
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // compare each result word with the oldest prediction
    always @(posedge aclk) begin : check_results
        grant_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_grants.size() == 0) begin
                report_mismatch("result with nothing pending", 32'(m_tdata), '0);
            end else begin
                want = pending_grants.pop_front();
                if (m_tuser !== want.ok)
                    report_mismatch("granted", 32'(m_tuser), 32'(want.ok));
                if (m_tdata[2:0] !== want.part)
                    report_mismatch("chosen_partition", 32'(m_tdata[2:0]), 32'(want.part));
                if (m_tdata[18:3] !== want.left)
                    report_mismatch("left_over", 32'(m_tdata[18:3]), 32'(want.left));
                if (m_tdata[TDATA_W-1:19] !== '0)
                    report_mismatch("tdata padding", 32'(m_tdata[TDATA_W-1:19]), '0);
            end
            result_count++;
        end
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // stimulus
    initial begin
        logic [2:0]  idx;
        logic [15:0] amt;
        for (int j = 0; j < NUM_PARTS; j++) part_cap[j] = '0;
        cur_fit   = FIT_FIRST;
        cur_count = 4'd8;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table, no idling
        for (int r = 0; r < NUM_DIR_ROWS; r++) begin
            if (DIR_ROWS[r].kind == ROW_CFG) begin
                wait_idle();
                write_reg(DIR_ROWS[r].idx[CFG_ADDR_W-1:0], DIR_ROWS[r].amt[CFG_DATA_W-1:0]);
            end else begin
                issue_word((DIR_ROWS[r].kind == ROW_REQ) ? OP_REQUEST : OP_LOAD,
                           DIR_ROWS[r].idx, DIR_ROWS[r].amt,
                           DIR_ROWS[r].typed, DIR_ROWS[r].want);
            end
        end

        // random phases, each setting the registers and one of four pacing modes
        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_idle();
            write_reg(REG_FIT_MODE, CFG_DATA_W'(PHASE_FIT[p]));
            write_reg(REG_PART_CNT, PHASE_COUNT[p]);
            case (p % 4)
                0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin sender_idle_pct = 64; recv_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  recv_stall_pct = 64; end
                default: begin sender_idle_pct = 21; recv_stall_pct = 21; end
            endcase
            for (int n = 0; n < WORDS_PER_PHASE; n++) begin
                idx = 3'($urandom_range(0, 7));
                if ($urandom_range(0, 99) < 35) begin
                    // refill a partition, mostly with wide capacities
                    amt = 16'($urandom_range(0, 65535));
                    if ($urandom_range(0, 3) == 0) amt = 16'($urandom_range(0, 4095));
                    if ($urandom_range(0, 15) == 0) amt = 16'hFFFF;
                    issue_word(OP_LOAD, idx, amt, 1'b0, NO_GRANT);
                end else begin
                    // requests aimed at small sizes, exact fits and edges
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3: amt = 16'($urandom_range(0, 1023));
                        4, 5:       amt = part_cap[$urandom_range(0, NUM_PARTS - 1)];
                        6:          amt = part_cap[$urandom_range(0, NUM_PARTS - 1)]
                                          + 16'($urandom_range(0, 2)) - 16'd1;
                        7:          amt = '0;
                        8:          amt = 16'($urandom_range(0, 65535));
                        default:    amt = 16'hFFFF;
                    endcase
                    issue_word(OP_REQUEST, idx, amt, 1'b0, NO_GRANT);
                end
            end
        end

        wait_idle();
        $display("covered %0d loads and %0d requests (%0d granted, %0d refused)",
                 load_count, request_count, granted_count, request_count - granted_count);
        $display("over %0d register writes and four pacing modes, %0d mismatches",
                 reg_write_count, mismatch_count);
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+hdl
hdl/fpa_pkg.sv
hdl/fit_policy_partition_allocator_core.sv
hdl/fpa_chk.sv
sim/fit_policy_partition_allocator_core_tb.sv
